FILE: hw/rtl/pncc_pkg.sv
package pncc_pkg;

	localparam int DEF_MAX_INPUT_DIMS   = 64;
	localparam int DEF_MAX_REDUCED_DIMS = 16;
	localparam int DEF_MAX_CLASSES      = 16;

	localparam int MODE_W     = 2;
	localparam int ROW_W      = 6;
	localparam int COL_W      = 4;
	localparam int VAL_W      = 32;
	localparam int CLS_W      = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	localparam logic [MODE_W-1:0] MODE_LOAD_FIRST  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_SECOND = 2'd1;
	localparam logic [MODE_W-1:0] MODE_LOAD_MEAN   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SAMPLE      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NUM_CLASSES     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INPUT_DIMS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REDUCED_DIMS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FISHER_DIMS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_METHOD = 3'd4;

	typedef enum logic [1:0] {
		OP_MAC1,
		OP_MAC2,
		OP_DIST
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC1,
		ST_WAIT1,
		ST_MAC2,
		ST_WAIT2,
		ST_DIST,
		ST_WAIT3,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic accept;
		logic issue;
		op_t  op;
		logic first;
		logic grp_last;
		logic finish;
		logic no_class;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic out_hold;
	} status_t;

	function automatic int clamp_cnt(int v, int hi);
		int r;
		r = v;
		if (v < 1) r = 1;
		else if (v > hi) r = hi;
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [48:0] x);
		logic signed [31:0] r;
		r = x[31:0];
		if (x > 49'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (x < -49'sh0_8000_0000) r = 32'sh8000_0000;
		return r;
	endfunction

endpackage

FILE: hw/rtl/pncc_ram.sv
module pncc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hw/rtl/pncc_ctrl.sv
module pncc_ctrl import pncc_pkg::*; #(
	parameter int MAX_INPUT_DIMS   = DEF_MAX_INPUT_DIMS,
	parameter int MAX_REDUCED_DIMS = DEF_MAX_REDUCED_DIMS,
	parameter int MAX_CLASSES      = DEF_MAX_CLASSES,
	localparam int RW  = (MAX_REDUCED_DIMS > 1) ? $clog2(MAX_REDUCED_DIMS) : 1,
	localparam int CLW = $clog2(MAX_CLASSES),
	localparam int ICW = $clog2(MAX_INPUT_DIMS + 1),
	localparam int RCW = $clog2(MAX_REDUCED_DIMS + 1),
	localparam int CCW = $clog2(MAX_CLASSES + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [MODE_W-1:0] mode,
	input  logic [ROW_W-1:0]  row_index,
	input  logic              last,
	input  logic [CCW-1:0]    nc,
	input  logic [ICW-1:0]    nin,
	input  logic [RCW-1:0]    nred,
	input  logic [RCW-1:0]    nfis,
	input  logic              method,
	input  status_t           st,
	output cmd_t              cmd,
	output logic [RW-1:0]     r_idx,
	output logic [RW-1:0]     k_idx,
	output logic [CLW-1:0]    c_idx
);

	state_t         state_q, state_d;
	logic [RW-1:0]  r_q, r_d, k_q, k_d;
	logic [CLW-1:0] c_q, c_d;
	logic           last_q, last_d;
	logic           r_end, k_end, c_end;

	assign r_end = (RCW'(r_q) == nred - RCW'(1));
	assign k_end = (RCW'(k_q) == nfis - RCW'(1));
	assign c_end = (CCW'(c_q) == nc - CCW'(1));
	assign r_idx = r_q;
	assign k_idx = k_q;
	assign c_idx = c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			r_q     <= '0;
			k_q     <= '0;
			c_q     <= '0;
			last_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			r_q     <= r_d;
			k_q     <= k_d;
			c_q     <= c_d;
			last_q  <= last_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		r_d      = r_q;
		k_d      = k_q;
		c_d      = c_q;
		last_d   = last_q;
		cmd      = '0;
		cmd.op   = OP_MAC1;
		in_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (mode == MODE_SAMPLE) begin
						last_d = last;
						r_d    = '0;
						k_d    = '0;
						c_d    = '0;
						if (int'(row_index) < int'(nin)) begin
							state_d = ST_MAC1;
						end else if (last) begin
							state_d = method ? ST_FINISH : ST_MAC2;
						end
					end
				end
			end
			ST_MAC1: begin
				cmd.issue = 1'b1;
				cmd.op    = OP_MAC1;
				if (r_end) begin
					r_d     = '0;
					state_d = ST_WAIT1;
				end else begin
					r_d = r_q + RW'(1);
				end
			end
			ST_WAIT1: begin
				if (!st.busy) begin
					if (!last_q) state_d = ST_IDLE;
					else state_d = method ? ST_FINISH : ST_MAC2;
				end
			end
			ST_MAC2: begin
				cmd.issue    = 1'b1;
				cmd.op       = OP_MAC2;
				cmd.first    = (r_q == '0);
				cmd.grp_last = r_end;
				if (r_end) begin
					r_d = '0;
					if (k_end) begin
						k_d     = '0;
						state_d = ST_WAIT2;
					end else begin
						k_d = k_q + RW'(1);
					end
				end else begin
					r_d = r_q + RW'(1);
				end
			end
			ST_WAIT2: begin
				if (!st.busy) state_d = ST_DIST;
			end
			ST_DIST: begin
				cmd.issue    = 1'b1;
				cmd.op       = OP_DIST;
				cmd.first    = (k_q == '0);
				cmd.grp_last = k_end;
				if (k_end) begin
					k_d = '0;
					if (c_end) begin
						c_d     = '0;
						state_d = ST_WAIT3;
					end else begin
						c_d = c_q + CLW'(1);
					end
				end else begin
					k_d = k_q + RW'(1);
				end
			end
			ST_WAIT3: begin
				if (!st.busy) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				// hold until the output register can take the word
				if (!st.out_hold) begin
					cmd.finish   = 1'b1;
					cmd.no_class = method;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hw/rtl/pncc_dp.sv
module pncc_dp import pncc_pkg::*; #(
	parameter int MAX_INPUT_DIMS   = DEF_MAX_INPUT_DIMS,
	parameter int MAX_REDUCED_DIMS = DEF_MAX_REDUCED_DIMS,
	parameter int MAX_CLASSES      = DEF_MAX_CLASSES,
	localparam int RW   = (MAX_REDUCED_DIMS > 1) ? $clog2(MAX_REDUCED_DIMS) : 1,
	localparam int CLW  = $clog2(MAX_CLASSES),
	localparam int FD   = MAX_INPUT_DIMS * MAX_REDUCED_DIMS,
	localparam int SD   = MAX_REDUCED_DIMS * MAX_REDUCED_DIMS,
	localparam int MD   = MAX_CLASSES * MAX_REDUCED_DIMS,
	localparam int FAW  = (FD > 1) ? $clog2(FD) : 1,
	localparam int SAW  = (SD > 1) ? $clog2(SD) : 1,
	localparam int MAW  = (MD > 1) ? $clog2(MD) : 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic [RW-1:0]           r_idx,
	input  logic [RW-1:0]           k_idx,
	input  logic [CLW-1:0]          c_idx,
	output status_t                 st,
	input  logic [MODE_W-1:0]       mode,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [COL_W-1:0]        col_index,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CLS_W-1:0]        class_index,
	output logic                    no_class
);

	logic [ROW_W-1:0]        row_q;
	logic signed [VAL_W-1:0] value_q;

	logic signed [31:0] acc_q  [MAX_REDUCED_DIMS];
	logic signed [31:0] proj_q [MAX_REDUCED_DIMS];
	logic signed [31:0] s_q;
	logic [55:0]        d_q, best_d_q;
	logic [CLW-1:0]     best_c_q;

	logic fp_we, sp_we, mn_we;
	logic [FAW-1:0] fp_waddr, fp_raddr;
	logic [SAW-1:0] sp_waddr, sp_raddr;
	logic [MAW-1:0] mn_waddr, mn_raddr;
	logic [31:0]    fp_rdata, sp_rdata, mn_rdata;

	logic           v_s1, v_s2, v_s3;
	op_t            op_s1, op_s2, op_s3;
	logic           first_s1, first_s2, first_s3;
	logic           gl_s1, gl_s2, gl_s3;
	logic [RW-1:0]  r_s1, r_s2, r_s3, k_s1, k_s2, k_s3;
	logic [CLW-1:0] c_s1, c_s2, c_s3;
	logic signed [33:0] a_s2, b_s2;
	logic signed [67:0] prod_s3;

	logic signed [31:0] op_a, op_b, mac_base, mac_res;
	logic signed [33:0] diff;
	logic signed [47:0] mac_term;
	logic [49:0]        dist_term;
	logic [55:0]        d_new;

	logic out_valid_q;
	logic [CLS_W-1:0] class_q;
	logic no_class_q;

	// load writes go straight to the stores at accept
	always_comb begin
		fp_we = cmd.accept && (mode == MODE_LOAD_FIRST) &&
			(int'(row_index) < MAX_INPUT_DIMS) && (int'(col_index) < MAX_REDUCED_DIMS);
		sp_we = cmd.accept && (mode == MODE_LOAD_SECOND) &&
			(int'(row_index) < MAX_REDUCED_DIMS) && (int'(col_index) < MAX_REDUCED_DIMS);
		mn_we = cmd.accept && (mode == MODE_LOAD_MEAN) &&
			(int'(row_index) < MAX_CLASSES) && (int'(col_index) < MAX_REDUCED_DIMS);
		fp_waddr = FAW'(int'(row_index) * MAX_REDUCED_DIMS + int'(col_index));
		sp_waddr = SAW'(int'(row_index) * MAX_REDUCED_DIMS + int'(col_index));
		mn_waddr = MAW'(int'(row_index) * MAX_REDUCED_DIMS + int'(col_index));
		fp_raddr = FAW'(int'(row_q) * MAX_REDUCED_DIMS + int'(r_idx));
		sp_raddr = SAW'(int'(r_idx) * MAX_REDUCED_DIMS + int'(k_idx));
		mn_raddr = MAW'(int'(c_idx) * MAX_REDUCED_DIMS + int'(k_idx));
	end

	pncc_ram #(.WIDTH(32), .DEPTH(FD)) u_first (
		.clk(clk), .we(fp_we), .waddr(fp_waddr), .wdata(value),
		.raddr(fp_raddr), .rdata(fp_rdata)
	);

	pncc_ram #(.WIDTH(32), .DEPTH(SD)) u_second (
		.clk(clk), .we(sp_we), .waddr(sp_waddr), .wdata(value),
		.raddr(sp_raddr), .rdata(sp_rdata)
	);

	pncc_ram #(.WIDTH(32), .DEPTH(MD)) u_means (
		.clk(clk), .we(mn_we), .waddr(mn_waddr), .wdata(value),
		.raddr(mn_raddr), .rdata(mn_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			row_q   <= row_index;
			value_q <= value;
		end
	end

	// operand select at the stage where the read data lands
	always_comb begin
		case (op_s1)
			OP_MAC1: begin
				op_a = value_q;
				op_b = fp_rdata;
			end
			OP_MAC2: begin
				op_a = acc_q[r_s1];
				op_b = sp_rdata;
			end
			OP_DIST: begin
				op_a = proj_q[k_s1];
				op_b = mn_rdata;
			end
			default: begin
				op_a = value_q;
				op_b = fp_rdata;
			end
		endcase
		diff = 34'(op_a) - 34'(op_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1    <= cmd.op;
		first_s1 <= cmd.first;
		gl_s1    <= cmd.grp_last;
		r_s1     <= r_idx;
		k_s1     <= k_idx;
		c_s1     <= c_idx;
		op_s2    <= op_s1;
		first_s2 <= first_s1;
		gl_s2    <= gl_s1;
		r_s2     <= r_s1;
		k_s2     <= k_s1;
		c_s2     <= c_s1;
		if (op_s1 == OP_DIST) begin
			a_s2 <= diff;
			b_s2 <= diff;
		end else begin
			a_s2 <= 34'(op_a);
			b_s2 <= 34'(op_b);
		end
		op_s3    <= op_s2;
		first_s3 <= first_s2;
		gl_s3    <= gl_s2;
		r_s3     <= r_s2;
		k_s3     <= k_s2;
		c_s3     <= c_s2;
		prod_s3  <= a_s2 * b_s2;
	end

	always_comb begin
		mac_term  = prod_s3[63:16];
		dist_term = prod_s3[65:16];
		if (op_s3 == OP_MAC1) mac_base = acc_q[r_s3];
		else mac_base = first_s3 ? 32'sd0 : s_q;
		mac_res = sat32(49'(mac_base) + 49'(mac_term));
		d_new   = (first_s3 ? 56'd0 : d_q) + 56'(dist_term);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_REDUCED_DIMS; i++) acc_q[i] <= '0;
		end else if (cmd.finish) begin
			for (int i = 0; i < MAX_REDUCED_DIMS; i++) acc_q[i] <= '0;
		end else if (v_s3 && op_s3 == OP_MAC1) begin
			acc_q[r_s3] <= mac_res;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && op_s3 == OP_MAC2) begin
			s_q <= mac_res;
			if (gl_s3) proj_q[k_s3] <= mac_res;
		end
		if (v_s3 && op_s3 == OP_DIST) begin
			d_q <= d_new;
			// earliest class wins ties
			if (gl_s3 && (c_s3 == '0 || d_new < best_d_q)) begin
				best_d_q <= d_new;
				best_c_q <= c_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			class_q    <= cmd.no_class ? '0 : CLS_W'(best_c_q);
			no_class_q <= cmd.no_class;
		end
	end

	assign st.busy     = v_s1 | v_s2 | v_s3;
	assign st.out_hold = out_valid_q & out_stall;
	assign out_valid   = out_valid_q;
	assign class_index = class_q;
	assign no_class    = no_class_q;

endmodule

FILE: hw/rtl/projected_nearest_centroid_classifier_unit.sv
// Projected nearest-centroid classifier.
// Input channel (in_valid/in_stall) carries one word per item: a load of a
// first-projection coefficient, a second-projection coefficient, a class mean
// element, or one sample element. A load leaves the block idle. A sample element runs
// reduced_dims multiply-accumulates through one shared pipelined multiplier
// and stalls the input until they drain; an element with an index at or
// past input_dims runs no multiply-accumulates of its own.
// On the word marked last the block adds the second projection
// (fisher_dims * reduced_dims MACs) and the distance search
// (num_classes * fisher_dims terms), each stage followed by a drain of the
// pipeline, then writes one word on the output channel (class_index,
// no_class); with distance method 1 it skips both and sets no_class.
// The output register holds its word while out_stall is high; the block keeps
// taking input words meanwhile, and waits only when the next result is ready.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and the user must make them only while the block is idle (not enforced).
// Reset clears control state and the accumulators and restores the default
// registers; the coefficient and mean stores hold nothing until loaded.
module projected_nearest_centroid_classifier_unit import pncc_pkg::*; #(
	parameter int MAX_INPUT_DIMS   = DEF_MAX_INPUT_DIMS,
	parameter int MAX_REDUCED_DIMS = DEF_MAX_REDUCED_DIMS,
	parameter int MAX_CLASSES      = DEF_MAX_CLASSES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_write,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic [ROW_W-1:0]        row_index,
	input  logic [COL_W-1:0]        col_index,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    last,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CLS_W-1:0]        class_index,
	output logic                    no_class
);

	localparam int RW  = (MAX_REDUCED_DIMS > 1) ? $clog2(MAX_REDUCED_DIMS) : 1;
	localparam int CLW = $clog2(MAX_CLASSES);
	localparam int ICW = $clog2(MAX_INPUT_DIMS + 1);
	localparam int RCW = $clog2(MAX_REDUCED_DIMS + 1);
	localparam int CCW = $clog2(MAX_CLASSES + 1);

	logic [4:0] num_classes_q, reduced_dims_q, fisher_dims_q;
	logic [6:0] input_dims_q;
	logic       method_q;

	logic [CCW-1:0] nc;
	logic [ICW-1:0] nin;
	logic [RCW-1:0] nred, nfis;

	cmd_t           cmd;
	status_t        st;
	logic [RW-1:0]  r_idx, k_idx;
	logic [CLW-1:0] c_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_classes_q  <= 5'd2;
			input_dims_q   <= 7'd64;
			reduced_dims_q <= 5'd16;
			fisher_dims_q  <= 5'd1;
			method_q       <= 1'b0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_NUM_CLASSES:     num_classes_q  <= cfg_data[4:0];
				CFG_INPUT_DIMS:      input_dims_q   <= cfg_data;
				CFG_REDUCED_DIMS:    reduced_dims_q <= cfg_data[4:0];
				CFG_FISHER_DIMS:     fisher_dims_q  <= cfg_data[4:0];
				CFG_DISTANCE_METHOD: method_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp counts into 1..max
	assign nc   = CCW'(clamp_cnt(int'(num_classes_q), MAX_CLASSES));
	assign nin  = ICW'(clamp_cnt(int'(input_dims_q), MAX_INPUT_DIMS));
	assign nred = RCW'(clamp_cnt(int'(reduced_dims_q), MAX_REDUCED_DIMS));
	assign nfis = RCW'(clamp_cnt(int'(fisher_dims_q), MAX_REDUCED_DIMS));

	pncc_ctrl #(
		.MAX_INPUT_DIMS(MAX_INPUT_DIMS),
		.MAX_REDUCED_DIMS(MAX_REDUCED_DIMS),
		.MAX_CLASSES(MAX_CLASSES)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .row_index(row_index), .last(last),
		.nc(nc), .nin(nin), .nred(nred), .nfis(nfis), .method(method_q),
		.st(st), .cmd(cmd),
		.r_idx(r_idx), .k_idx(k_idx), .c_idx(c_idx)
	);

	pncc_dp #(
		.MAX_INPUT_DIMS(MAX_INPUT_DIMS),
		.MAX_REDUCED_DIMS(MAX_REDUCED_DIMS),
		.MAX_CLASSES(MAX_CLASSES)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .r_idx(r_idx), .k_idx(k_idx), .c_idx(c_idx), .st(st),
		.mode(mode), .row_index(row_index), .col_index(col_index), .value(value),
		.out_valid(out_valid), .out_stall(out_stall),
		.class_index(class_index), .no_class(no_class)
	);

endmodule
